// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, command codes and the front-to-back transaction type.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned CmdWidth        = 3;
  localparam int unsigned NumOutWidth     = 33;
  localparam int unsigned DenOutWidth     = 32;
  localparam int unsigned MagWidth        = 33;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [CmdWidth-1:0] CmdAdd = 3'd0;
  localparam logic [CmdWidth-1:0] CmdSub = 3'd1;
  localparam logic [CmdWidth-1:0] CmdMul = 3'd2;
  localparam logic [CmdWidth-1:0] CmdDiv = 3'd3;
  localparam logic [CmdWidth-1:0] CmdCmp = 3'd4;

  // Classified transaction: either needs reduction or is already final.
  typedef struct packed {
    logic                          reduce;
    logic signed [NumOutWidth-1:0] num;
    logic signed [DenOutWidth-1:0] den;
    logic                          is_equal;
    logic                          zero_den_error;
  } rau_txn_t;

endpackage

// ===== design/rau_front.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Cross-multiplies the operands over two registered stages and classifies.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic [CmdWidth-1:0]     command_i,
  input  logic signed [OperandWidthDef-1:0] a_num_i,
  input  logic signed [OperandWidthDef-1:0] a_den_i,
  input  logic signed [OperandWidthDef-1:0] b_num_i,
  input  logic signed [OperandWidthDef-1:0] b_den_i,
  output logic                    valid_o,
  output rau_txn_t                txn_o
);

  localparam int unsigned PW = 2 * OperandWidthDef;

  logic                    v1_q;
  logic [CmdWidth-1:0]     cmd_q;
  logic                    eq_q;
  logic signed [PW-1:0]    p0_q, p1_q, p2_q;
  logic                    v2_q;
  rau_txn_t                txn_q;
  logic signed [PW-1:0]    p0_d, p1_d, p2_d;
  logic signed [PW:0]      n_w;
  logic signed [PW:0]      d_w;
  rau_txn_t                txn_d;

  always_comb begin
    p0_d = '0;
    p1_d = '0;
    p2_d = '0;
    case (command_i)
      CmdAdd, CmdSub: begin
        p0_d = PW'(a_num_i) * PW'(b_den_i);
        p1_d = PW'(a_den_i) * PW'(b_num_i);
        p2_d = PW'(a_den_i) * PW'(b_den_i);
      end
      CmdMul: begin
        p0_d = PW'(a_num_i) * PW'(b_num_i);
        p2_d = PW'(a_den_i) * PW'(b_den_i);
      end
      CmdDiv: begin
        p0_d = PW'(a_num_i) * PW'(b_den_i);
        p2_d = PW'(a_den_i) * PW'(b_num_i);
      end
      default: ;
    endcase
  end

  always_comb begin
    n_w   = {p0_q[PW-1], p0_q};
    d_w   = {p2_q[PW-1], p2_q};
    txn_d = '0;
    case (cmd_q)
      CmdAdd: n_w = {p0_q[PW-1], p0_q} + {p1_q[PW-1], p1_q};
      CmdSub: n_w = {p0_q[PW-1], p0_q} - {p1_q[PW-1], p1_q};
      default: ;
    endcase
    case (cmd_q)
      CmdAdd, CmdSub, CmdMul, CmdDiv: begin
        if (d_w == '0) begin
          txn_d.num            = NumOutWidth'(n_w);
          txn_d.den            = DenOutWidth'(1);
          txn_d.zero_den_error = 1'b1;
          if (n_w == '0) txn_d.num = '0;
        end else if (n_w == '0) begin
          txn_d.den = DenOutWidth'(1);
        end else begin
          txn_d.reduce = 1'b1;
          txn_d.num    = NumOutWidth'(n_w);
          txn_d.den    = DenOutWidth'(d_w);
        end
      end
      CmdCmp: begin
        txn_d.den      = DenOutWidth'(1);
        txn_d.is_equal = eq_q;
      end
      default: txn_d.den = DenOutWidth'(1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) begin
      cmd_q <= command_i;
      eq_q  <= (a_num_i == b_num_i) && (a_den_i == b_den_i);
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
    end
    if (v1_q) txn_q <= txn_d;
  end

  assign valid_o = v2_q;
  assign txn_o   = txn_q;

endmodule

// ===== design/rau_queue.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit queue
// Small FIFO between the front end and the reduction back end.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rau_txn_t data_i,
  input  logic     pop_i,
  output logic     valid_o,
  output rau_txn_t data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  rau_txn_t            mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

// ===== design/rau_back.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Binary GCD of the magnitudes, then two restoring divisions by the GCD.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rau_txn_t                      txn_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic signed [NumOutWidth-1:0] result_num_o,
  output logic signed [DenOutWidth-1:0] result_den_o,
  output logic                          is_equal_o,
  output logic                          zero_den_error_o
);

  localparam int unsigned CntW = $clog2(MagWidth + 1);

  typedef enum logic [2:0] {
    StIdle, StShift, StGcd, StDivN, StDivD, StOut
  } state_e;

  state_e               state_q;
  logic [MagWidth-1:0]  x_q, y_q, g_q, quo_q, rem_q, dvd_q, qn_q;
  logic [CntW-1:0]      k_q, bit_q;
  logic                 neg_n_q, neg_d_q;
  logic                 done_q, eq_q, err_q;
  logic signed [NumOutWidth-1:0] num_q;
  logic signed [DenOutWidth-1:0] den_q;
  logic [MagWidth-1:0]  rem_sh;
  logic [MagWidth:0]    rem_sub;
  logic [MagWidth-1:0]  mag_n, mag_d;

  assign mag_n  = txn_i.num[NumOutWidth-1] ? MagWidth'(-txn_i.num) : MagWidth'(txn_i.num);
  assign mag_d  = txn_i.den[DenOutWidth-1] ?
                  MagWidth'(-{txn_i.den[DenOutWidth-1], txn_i.den}) :
                  MagWidth'(txn_i.den);
  assign rem_sh  = {rem_q[MagWidth-2:0], dvd_q[MagWidth-1]};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, g_q};
  assign pop_o   = (state_q == StIdle) && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      quo_q   <= '0;
      qn_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (valid_i) begin
            eq_q  <= txn_i.is_equal;
            err_q <= txn_i.zero_den_error;
            num_q <= txn_i.num;
            den_q <= txn_i.den;
            if (txn_i.reduce) begin
              x_q     <= mag_n;
              y_q     <= mag_d;
              neg_n_q <= txn_i.num[NumOutWidth-1];
              neg_d_q <= txn_i.den[DenOutWidth-1];
              k_q     <= '0;
              state_q <= StShift;
            end else begin
              state_q <= StOut;
            end
          end
        end
        // strip common factors of two
        StShift: begin
          if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= StGcd;
          end
        end
        StGcd: begin
          if (!x_q[0]) x_q <= x_q >> 1;
          else if (!y_q[0]) y_q <= y_q >> 1;
          else if (x_q == y_q) begin
            g_q     <= x_q << k_q;
            dvd_q   <= neg_n_q ? MagWidth'(-num_q) : MagWidth'(num_q);
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= StDivN;
          end else if (x_q > y_q) x_q <= (x_q - y_q) >> 1;
          else y_q <= (y_q - x_q) >> 1;
        end
        StDivN, StDivD: begin
          dvd_q <= {dvd_q[MagWidth-2:0], !rem_sub[MagWidth]};
          rem_q <= rem_sub[MagWidth] ? rem_sh : rem_sub[MagWidth-1:0];
          if (bit_q == CntW'(MagWidth - 1)) begin
            bit_q <= '0;
            rem_q <= '0;
            if (state_q == StDivN) begin
              qn_q    <= {dvd_q[MagWidth-2:0], !rem_sub[MagWidth]};
              dvd_q   <= neg_d_q ? MagWidth'(-{den_q[DenOutWidth-1], den_q})
                                 : MagWidth'(den_q);
              state_q <= StDivD;
            end else begin
              quo_q   <= {dvd_q[MagWidth-2:0], !rem_sub[MagWidth]};
              state_q <= StOut;
            end
          end else begin
            bit_q <= bit_q + 1'b1;
          end
        end
        StOut: begin
          if (quo_q != '0 || qn_q != '0) begin
            num_q <= neg_n_q ? -NumOutWidth'(qn_q) : NumOutWidth'(qn_q);
            den_q <= neg_d_q ? -DenOutWidth'(quo_q) : DenOutWidth'(quo_q);
          end
          quo_q   <= '0;
          qn_q    <= '0;
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign done_o           = done_q;
  assign result_num_o     = num_q;
  assign result_den_o     = den_q;
  assign is_equal_o       = eq_q;
  assign zero_den_error_o = err_q;

endmodule

// ===== design/rational_arith_unit.sv =====
// Sequence: compare, zero and error cases skip the reduction; a reduced result
// takes the binary GCD steps plus two 33-step divisions.
// Throughput: one transaction at a time through the reduction sequencer;
// busy stays high from acceptance until the result strobe.
// Reset clears all control state; the receiver cannot stall results.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction add, subtract, multiply, divide and compare, reduced by GCD.
// ----------------------------------------------------------------------------
module rational_arith_unit import rau_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [CmdWidth-1:0]            command_i,
  input  logic signed [OperandWidthDef-1:0] a_num_i,
  input  logic signed [OperandWidthDef-1:0] a_den_i,
  input  logic signed [OperandWidthDef-1:0] b_num_i,
  input  logic signed [OperandWidthDef-1:0] b_den_i,
  output logic                           result_valid_o,
  output logic signed [NumOutWidth-1:0]  result_num_o,
  output logic signed [DenOutWidth-1:0]  result_den_o,
  output logic                           is_equal_o,
  output logic                           zero_den_error_o
);

  logic     busy_q;
  logic     f_valid, q_valid, pop, done;
  rau_txn_t f_txn, q_txn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (start_i && !busy_q) busy_q <= 1'b1;
    else if (done) busy_q <= 1'b0;
  end
  assign busy_o = busy_q;

  rau_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_q), .command_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .valid_o(f_valid), .txn_o(f_txn)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_txn),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_txn)
  );

  rau_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .txn_i(q_txn), .pop_o(pop),
    .done_o(done), .result_num_o, .result_den_o, .is_equal_o, .zero_den_error_o
  );

  assign result_valid_o = done;

endmodule
